/* design/assert_macros.svh */
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define KBSC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define KBSC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KBSC_ASSERT_IMP(lbl, ante, cons, msg)
`define KBSC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* design/kbsc_pkg.sv */
// types, constants and helper functions of the keyed block scrambler
package kbsc_pkg;

  localparam int BLOCK_WORDS_DEF = 11;
  localparam int MAX_RES = 5;
  localparam int CNT_W = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [15:0] KEY_TWEAK = 16'h38aa;
  localparam logic [31:0] SIGNATURE = 32'h5c331a55;
  localparam logic [2:0] HDR_LEN = 3'd4;

  localparam logic DIR_SCRAMBLE = 1'b0;

  localparam logic [REG_IDX_W-1:0] REG_DIRECTION = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_ADJ = 1'd1;

  typedef struct packed {
    logic direction;
    logic key_adj;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       pass;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             load_ok;
  } obuf_st_t;

  // key word per word slot of a block
  function automatic logic [15:0] key_word(input logic [3:0] idx);
    logic [15:0] k;
    case (idx)
      4'd0: k = 16'ha820;
      4'd1: k = 16'h71f0;
      4'd2: k = 16'h88da;
      4'd3: k = 16'h1fff;
      4'd4: k = 16'h2718;
      4'd5: k = 16'he6a1;
      4'd6: k = 16'h42b8;
      4'd7: k = 16'h0ce9;
      4'd8: k = 16'h10ec;
      4'd9: k = 16'hd77d;
      4'd10: k = 16'h3fa9;
      default: k = 16'h0000;
    endcase
    return k;
  endfunction

  // remainder by 255 through folding, since 256 is 1 mod 255
  function automatic logic [7:0] mod255(input logic [16:0] x);
    logic [9:0] s1;
    logic [8:0] s2;
    s1 = 10'(x[16:8]) + 10'(x[7:0]);
    s2 = 9'(s1[9:8]) + 9'(s1[7:0]);
    if (s2 >= 9'd255) begin
      s2 = s2 - 9'd255;
    end
    return s2[7:0];
  endfunction

endpackage

/* design/kbsc_cfg.sv */
// register file behind the configuration port
module kbsc_cfg import kbsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  logic                 direction_r;
  logic                 key_adj_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[CFG_ADDR_W-1 -: REG_IDX_W];
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      key_adj_r <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIRECTION: direction_r <= cfg_pwdata[0];
        REG_KEY_ADJ: key_adj_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DIRECTION: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, direction_r};
      REG_KEY_ADJ: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, key_adj_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign cfg.direction = direction_r;
  assign cfg.key_adj = key_adj_r;

endmodule

/* design/kbsc_core.sv */
// per-byte scramble, header handling and chained checksum state
module kbsc_core import kbsc_pkg::*; #(
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    in_accept,
  input  logic [7:0]              in_byte,
  input  logic                    in_eos,
  output res_t [MAX_RES-1:0]      res,
  output logic [CNT_W-1:0]        res_cnt
);

  localparam int BLK_LEN = 2 * BLOCK_WORDS;
  localparam int POS_W = $clog2(BLK_LEN);

  logic [POS_W-1:0] pos_r;
  logic [15:0]      prior_ck_r;
  logic [16:0]      sum_a_r;
  logic [7:0]       sum_b_r;
  logic [2:0]       hdr_cnt_r;
  logic             pass_r;
  logic [7:0]       held_r [3];

  logic [3:0]       key_idx;
  logic [15:0]      key;
  logic [15:0]      ks;
  logic [7:0]       lane;
  logic [7:0]       body_out;
  logic [7:0]       cipher;
  logic [16:0]      sa_sum;
  logic [16:0]      sa_new;
  logic [7:0]       sb_new;
  logic [POS_W:0]   pos_inc;
  logic             blk_end;
  logic [15:0]      ck_new;
  logic [2:0]       hdr_inc;
  logic             sig_ok;

  logic [2:0]       hdr_nxt;
  logic             pass_nxt;
  logic             use_body;
  logic             held_we;

  // keystream byte and checksum step
  always_comb begin
    key_idx = 4'(pos_r >> 1);
    key = key_word(key_idx) ^ (cfg.key_adj ? KEY_TWEAK : 16'h0000);
    ks = key ^ prior_ck_r;
    lane = pos_r[0] ? ks[15:8] : ks[7:0];
    // lone final byte of an odd stream goes out as is
    body_out = (in_eos && !pos_r[0]) ? in_byte : (in_byte ^ lane);
    cipher = (cfg.direction == DIR_SCRAMBLE) ? body_out : in_byte;
    sa_sum = sum_a_r + 17'(cipher);
    sa_new = (sa_sum >= 17'd255) ? (sa_sum - 17'd255) : sa_sum;
    sb_new = mod255(17'(sum_b_r) + sa_new);
    pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);
    blk_end = (pos_inc >= (POS_W+1)'(BLK_LEN));
    ck_new = {sa_new[7:0], sb_new};
  end

  assign hdr_inc = hdr_cnt_r + 3'd1;
  assign sig_ok = (held_r[0] == SIGNATURE[7:0]) && (held_r[1] == SIGNATURE[15:8]) &&
                  (held_r[2] == SIGNATURE[23:16]) && (in_byte == SIGNATURE[31:24]);

  // result set for the byte at the input
  always_comb begin
    res = '0;
    res_cnt = '0;
    use_body = 1'b0;
    held_we = 1'b0;
    hdr_nxt = hdr_cnt_r;
    pass_nxt = pass_r;
    if (cfg.direction == DIR_SCRAMBLE) begin
      use_body = 1'b1;
      if (hdr_cnt_r < HDR_LEN) begin
        for (int i = 0; i < 4; i++) begin
          res[i] = '{data: SIGNATURE[8*i +: 8], fin: 1'b0, pass: 1'b0};
        end
        res[4] = '{data: body_out, fin: in_eos, pass: 1'b0};
        res_cnt = CNT_W'(MAX_RES);
        hdr_nxt = HDR_LEN;
      end else begin
        res[0] = '{data: body_out, fin: in_eos, pass: 1'b0};
        res_cnt = CNT_W'(1);
      end
    end else if (pass_r) begin
      res[0] = '{data: in_byte, fin: in_eos, pass: 1'b1};
      res_cnt = CNT_W'(1);
    end else if (hdr_cnt_r < HDR_LEN) begin
      held_we = 1'b1;
      hdr_nxt = hdr_inc;
      if (hdr_inc == HDR_LEN) begin
        if (!sig_ok) begin
          pass_nxt = 1'b1;
          for (int i = 0; i < 3; i++) begin
            res[i] = '{data: held_r[i], fin: 1'b0, pass: 1'b1};
          end
          res[3] = '{data: in_byte, fin: in_eos, pass: 1'b1};
          res_cnt = CNT_W'(4);
        end
      end else if (in_eos) begin
        // short stream: flush what was held
        for (int i = 0; i < 3; i++) begin
          if (3'(i) < hdr_inc) begin
            res[i] = '{data: (3'(i + 1) == hdr_inc) ? in_byte : held_r[i],
                       fin: (3'(i + 1) == hdr_inc), pass: 1'b1};
          end
        end
        res_cnt = CNT_W'(hdr_inc);
      end
    end else begin
      use_body = 1'b1;
      res[0] = '{data: body_out, fin: in_eos, pass: 1'b0};
      res_cnt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      prior_ck_r <= 16'hffff;
      sum_a_r <= 17'd65535;
      sum_b_r <= 8'd0;
      hdr_cnt_r <= 3'd0;
      pass_r <= 1'b0;
    end else if (in_accept) begin
      if (in_eos) begin
        pos_r <= '0;
        prior_ck_r <= 16'hffff;
        sum_a_r <= 17'd65535;
        sum_b_r <= 8'd0;
        hdr_cnt_r <= 3'd0;
        pass_r <= 1'b0;
      end else begin
        hdr_cnt_r <= hdr_nxt;
        pass_r <= pass_nxt;
        if (use_body) begin
          if (blk_end) begin
            pos_r <= '0;
            prior_ck_r <= ck_new;
            sum_a_r <= 17'(ck_new);
            sum_b_r <= mod255(17'(ck_new));
          end else begin
            pos_r <= pos_inc[POS_W-1:0];
            sum_a_r <= sa_new;
            sum_b_r <= sb_new;
          end
        end
      end
    end
  end

  // the fourth header byte is compared in flight and never stored
  always_ff @(posedge clk) begin
    if (in_accept && held_we && (hdr_cnt_r[1:0] != 2'd3)) begin
      held_r[hdr_cnt_r[1:0]] <= in_byte;
    end
  end

endmodule

/* design/kbsc_obuf.sv */
// result register: holds one byte's result set and shifts it out
module kbsc_obuf import kbsc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  res_t [MAX_RES-1:0] res,
  input  logic [CNT_W-1:0]   res_cnt,
  input  logic               out_ready,
  output logic               out_valid,
  output res_t               out_res,
  output obuf_st_t           st
);

  res_t [MAX_RES-1:0] slot_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_res = slot_r[0];
  assign pop = out_valid && out_ready;
  assign st.count = cnt_r;
  assign st.load_ok = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= res_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

/* design/keyed_block_scrambler_checksum_chain.sv */
// top level: keyed byte scrambler/descrambler with chained block checksum
// a request's first result is registered and on the output in the cycle after it is accepted
// throughput: one byte per cycle while each byte gives one result and the sink is ready
// a byte with n results holds the output until all n have left (5 for the first scrambled byte)
// the five-slot result register sets the rate: the next byte enters as the last slot drains
// reset: synchronous, active low; stream state and registers to defaults, output empty
module keyed_block_scrambler_checksum_chain import kbsc_pkg::*; #(
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_stream
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] out_byte
  output logic                  out_tlast,  // out_final
  output logic                  out_tuser,  // [0] unsigned_pass
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  `include "assert_macros.svh"

  cfg_t               cfg;
  res_t [MAX_RES-1:0] res;
  logic [CNT_W-1:0]   res_cnt;
  res_t               out_res;
  obuf_st_t           obuf_st;
  logic               in_accept;

  // direction and key adjust registers
  kbsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // a new request may enter when the result register is empty or its last slot leaves now
  assign in_tready = obuf_st.load_ok;
  assign in_accept = in_tvalid && in_tready;

  // all per-byte work: signature, header check, keystream xor, checksum update
  kbsc_core #(
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .in_eos    (in_tlast),
    .res       (res),
    .res_cnt   (res_cnt)
  );

  // result register, drained one result per cycle while the sink is ready
  kbsc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .res       (res),
    .res_cnt   (res_cnt),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .st        (obuf_st)
  );

  assign out_tdata = out_res.data;
  assign out_tlast = out_res.fin;
  assign out_tuser = out_res.pass;

  // a new request never overwrites more than the result leaving this cycle
  `KBSC_ASSERT_IMP(a_no_overwrite, in_tready, obuf_st.count <= CNT_W'(1), "result overwritten")

  // the stream-final result is always the last of its set
  `KBSC_ASSERT_NXT(a_final_last, out_tvalid && out_tready && out_tlast && !in_accept,
                   !out_tvalid, "result after final")

endmodule

/* test/keyed_block_scrambler_checksum_chain_tb.sv */
// self-checking testbench for the keyed block scrambler with chained block checksum
module keyed_block_scrambler_checksum_chain_tb;
  import kbsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_BYTES = 2 * BLOCK_WORDS_DEF;
  localparam int RANDOM_BYTES = 325;
  localparam int PHASE_BYTES = 40;
  localparam int SETTLE_CYCLES = 8;     // block may still be busy after the last result
  localparam int HOLD_CYCLES = 200;     // long receiver hold-off
  localparam int QUIET_LIMIT = 3000;    // cycles with no handshake before giving up
  localparam logic DIR_DESCRAMBLE = ~DIR_SCRAMBLE;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  // block ports
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  keyed_block_scrambler_checksum_chain uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // scrambler model: register copies and per-stream state
  // ---------------------------------------------------------------------------
  logic        dir_cfg = DIR_SCRAMBLE;
  logic        keyadj_cfg = 1'b1;

  logic [4:0]  blk_pos;       // byte slot inside the current block
  logic [15:0] chain_ck;      // checksum handed on from the previous block
  int          sum_a;
  int          sum_b;
  int          hdr_cnt;       // signature bytes seen or sent
  logic [7:0]  hdr_buf [4];   // descrambler's held signature candidates
  logic        pass_thru;     // descrambler found no signature

  logic [15:0] key_words [BLOCK_WORDS_DEF] = '{
    16'ha820, 16'h71f0, 16'h88da, 16'h1fff, 16'h2718, 16'he6a1,
    16'h42b8, 16'h0ce9, 16'h10ec, 16'hd77d, 16'h3fa9
  };

  res_t fresh_bytes [$];      // results of the request just accepted
  res_t awaited_bytes [$];    // results still due from the block

  int errors = 0;

  function automatic void restart_stream();
    blk_pos = '0;
    chain_ck = 16'hffff;
    sum_a = 65535;
    sum_b = 0;
    hdr_cnt = 0;
    pass_thru = 1'b0;
  endfunction

  // xor one body byte with its key lane and fold the ciphertext into the checksum
  function automatic logic [7:0] xor_and_sum(input logic [7:0] b, input logic eos,
                                             input logic enc);
    logic [15:0] kw;
    logic [15:0] ks;
    logic [7:0]  lane;
    logic [7:0]  ob;
    logic [7:0]  cb;
    int          wi;
    wi = int'(blk_pos) >> 1;
    kw = (wi < BLOCK_WORDS_DEF) ? key_words[wi] : 16'h0000;
    if (keyadj_cfg) begin
      kw = kw ^ KEY_TWEAK;
    end
    ks = kw ^ chain_ck;
    lane = blk_pos[0] ? ks[15:8] : ks[7:0];
    // a lone final byte on an even slot goes out untouched
    ob = (eos && !blk_pos[0]) ? b : (b ^ lane);
    cb = enc ? ob : b;
    sum_a = sum_a + int'(cb);
    if (sum_a >= 255) begin
      sum_a = sum_a - 255;
    end
    sum_a = sum_a & 32'h1ffff;
    sum_b = (sum_b + sum_a) % 255;
    if (int'(blk_pos) + 1 >= BLOCK_BYTES || eos) begin
      chain_ck = {sum_a[7:0], sum_b[7:0]};
      sum_a = int'(chain_ck);
      sum_b = int'(chain_ck) % 255;
      blk_pos = '0;
    end else begin
      blk_pos = blk_pos + 5'd1;
    end
    return ob;
  endfunction

  // work out every result that one accepted request causes
  function automatic void predict_stream_bytes(input logic [7:0] b, input logic eos);
    logic [7:0] ob;
    logic       match;
    fresh_bytes.delete();
    if (dir_cfg == DIR_SCRAMBLE) begin
      if (hdr_cnt < 4) begin
        for (int i = 0; i < 4; i++) begin
          fresh_bytes.push_back({SIGNATURE[8*i +: 8], 1'b0, 1'b0});
        end
        hdr_cnt = 4;
      end
      ob = xor_and_sum(b, eos, 1'b1);
      fresh_bytes.push_back({ob, eos, 1'b0});
    end else if (pass_thru) begin
      fresh_bytes.push_back({b, eos, 1'b1});
    end else if (hdr_cnt < 4) begin
      hdr_buf[hdr_cnt] = b;
      hdr_cnt = hdr_cnt + 1;
      if (hdr_cnt == 4) begin
        match = ({hdr_buf[3], hdr_buf[2], hdr_buf[1], hdr_buf[0]} == SIGNATURE);
        if (!match) begin
          // no signature: release the held bytes and pass everything from now on
          pass_thru = 1'b1;
          for (int i = 0; i < 4; i++) begin
            fresh_bytes.push_back({hdr_buf[i], eos && (i == 3), 1'b1});
          end
        end
      end else if (eos) begin
        // stream too short to carry a signature
        for (int i = 0; i < hdr_cnt; i++) begin
          fresh_bytes.push_back({hdr_buf[i], i + 1 == hdr_cnt, 1'b1});
        end
      end
    end else begin
      ob = xor_and_sum(b, eos, 1'b0);
      fresh_bytes.push_back({ob, eos, 1'b0});
    end
    if (eos) begin
      restart_stream();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking and watchdog
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tlast, out_tuser};
        if (awaited_bytes.size() == 0) begin
          report_mismatch("result with nothing due, byte", got.data, 8'h00);
        end else begin
          want = awaited_bytes.pop_front();
          if (got.data !== want.data) begin
            report_mismatch("out_byte", got.data, want.data);
          end
          if (got.fin !== want.fin) begin
            report_mismatch("out_final", {7'd0, got.fin}, {7'd0, want.fin});
          end
          if (got.pass !== want.pass) begin
            report_mismatch("unsigned_pass", {7'd0, got.pass}, {7'd0, want.pass});
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall pattern re-picked at random from four modes, long hold-off on request
  // ---------------------------------------------------------------------------
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          sink_mode = 0;
  logic [31:0] sink_cyc = '0;

  always @(posedge clk) begin
    sink_cyc = sink_cyc + 1;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (sink_cyc % 80 == 0) begin
      sink_mode = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (sink_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (sink_cyc[2:0] != 3'd3) && (sink_cyc[2:0] != 3'd4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  int burst_left = 4;
  bit steady_phase = 1'b0;
  int bytes_sent = 0;

  // offer one request, wait for the handshake, then maybe leave a gap
  task automatic offer_byte(input logic [7:0] b, input logic eos, input bit use_model);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    predict_stream_bytes(b, eos);
    if (use_model) begin
      foreach (fresh_bytes[i]) awaited_bytes.push_back(fresh_bytes[i]);
    end
    bytes_sent++;
    if (!steady_phase && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // registers change only with the block drained and settled
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic value);
    in_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_DIRECTION) begin
      dir_cfg = value;
    end else begin
      keyadj_cfg = value;
    end
  endtask

  // one random stream; descrambling mostly gets a valid signature up front
  task automatic play_stream(output int sent);
    logic [7:0] strm [$];
    int         len;
    int         pick;
    int         k;
    bit         close;
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 4))
        0: len = BLOCK_BYTES - 1;
        1: len = BLOCK_BYTES;
        2: len = BLOCK_BYTES + 1;
        3: len = 2 * BLOCK_BYTES;
        default: len = 2 * BLOCK_BYTES + 1;
      endcase
    end else begin
      len = $urandom_range(1, 30);
    end
    if (dir_cfg == DIR_DESCRAMBLE) begin
      pick = $urandom_range(0, 9);
      if (pick <= 7) begin
        for (int i = 0; i < 4; i++) begin
          strm.push_back(SIGNATURE[8*i +: 8]);
        end
        if (pick >= 6) begin
          // one flipped bit spoils the signature
          k = $urandom_range(0, 3);
          strm[k] = strm[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (pick == 0) begin
          len = 0;   // signature alone
        end
      end else if (pick == 9) begin
        len = $urandom_range(1, 3);   // shorter than a signature
      end
    end
    for (int i = 0; i < len; i++) begin
      strm.push_back(8'($urandom_range(0, 255)));
    end
    // now and then a stream stays open and runs into the next one
    close = ($urandom_range(0, 9) != 0);
    foreach (strm[i]) begin
      offer_byte(strm[i], close && (i == strm.size() - 1), 1'b1);
    end
    sent = strm.size();
  endtask

  // directed script: bytes and register writes, some results typed in by hand
  typedef enum logic [1:0] {ROW_BYTE, ROW_DIR, ROW_KEYADJ} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [2:0] n_res;
  } row_t;

  localparam int N_ROWS = 30;
  localparam int N_TYPED = 18;

  row_t script [N_ROWS] = '{
    // scramble after reset: signature then first ciphertext byte
    '{ROW_BYTE,   8'h00, 1'b0, 1'b1, 3'd5},
    '{ROW_BYTE,   8'hff, 1'b0, 1'b0, 3'd0},
    // lone final byte on an even slot is not xored
    '{ROW_BYTE,   8'ha5, 1'b1, 1'b1, 3'd1},
    // one-byte stream
    '{ROW_BYTE,   8'h3c, 1'b1, 1'b1, 3'd5},
    '{ROW_KEYADJ, 8'h00, 1'b0, 1'b0, 3'd0},
    '{ROW_BYTE,   8'h80, 1'b0, 1'b0, 3'd0},
    '{ROW_BYTE,   8'h01, 1'b1, 1'b0, 3'd0},
    '{ROW_DIR,    {7'd0, DIR_DESCRAMBLE}, 1'b0, 1'b0, 3'd0},
    // signed stream: signature stripped, body descrambled
    '{ROW_BYTE,   8'h55, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h1a, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h33, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h5c, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h12, 1'b0, 1'b0, 3'd0},
    '{ROW_BYTE,   8'h34, 1'b1, 1'b0, 3'd0},
    // stream ending right on the signature gives nothing
    '{ROW_BYTE,   8'h55, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h1a, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h33, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h5c, 1'b1, 1'b1, 3'd0},
    // short unsigned stream comes back as held
    '{ROW_BYTE,   8'h00, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'hff, 1'b1, 1'b1, 3'd2},
    // wrong signature: whole stream passes unchanged
    '{ROW_BYTE,   8'h55, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h1a, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h33, 1'b0, 1'b1, 3'd0},
    '{ROW_BYTE,   8'h5d, 1'b0, 1'b1, 3'd4},
    '{ROW_BYTE,   8'h77, 1'b1, 1'b1, 3'd1},
    // direction flips in the middle of a stream
    '{ROW_BYTE,   8'h55, 1'b0, 1'b1, 3'd0},
    '{ROW_DIR,    {7'd0, DIR_SCRAMBLE}, 1'b0, 1'b0, 3'd0},
    '{ROW_BYTE,   8'h42, 1'b0, 1'b0, 3'd0},
    '{ROW_DIR,    {7'd0, DIR_DESCRAMBLE}, 1'b0, 1'b0, 3'd0},
    '{ROW_BYTE,   8'h43, 1'b1, 1'b0, 3'd0}
  };

  // fields: byte, final, unsigned pass
  res_t typed_bytes [N_TYPED] = '{
    {8'h55, 2'b00}, {8'h1a, 2'b00}, {8'h33, 2'b00}, {8'h5c, 2'b00}, {8'h75, 2'b00},
    {8'ha5, 2'b10},
    {8'h55, 2'b00}, {8'h1a, 2'b00}, {8'h33, 2'b00}, {8'h5c, 2'b00}, {8'h3c, 2'b10},
    {8'h00, 2'b01}, {8'hff, 2'b11},
    {8'h55, 2'b01}, {8'h1a, 2'b01}, {8'h33, 2'b01}, {8'h5d, 2'b01},
    {8'h77, 2'b11}
  };

  initial begin : stimulus
    int ti;
    int phase_no;
    int phase_bytes;
    int rand_bytes;
    int n;
    restart_stream();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    ti = 0;
    for (int r = 0; r < N_ROWS; r++) begin
      case (script[r].kind)
        ROW_BYTE: begin
          // typed results are due before the request goes out, so a gap cannot outrun them
          if (script[r].typed) begin
            repeat (script[r].n_res) begin
              awaited_bytes.push_back(typed_bytes[ti]);
              ti++;
            end
          end
          offer_byte(script[r].data, script[r].last, !script[r].typed);
        end
        ROW_DIR: begin
          write_reg(REG_DIRECTION, script[r].data[0]);
        end
        default: begin
          write_reg(REG_KEY_ADJ, script[r].data[0]);
        end
      endcase
    end

    // random part: each phase drains, sets both registers and plays streams
    phase_no = 0;
    rand_bytes = 0;
    while (rand_bytes < RANDOM_BYTES) begin
      if (phase_no < 4) begin
        write_reg(REG_DIRECTION, phase_no[1] ? DIR_DESCRAMBLE : DIR_SCRAMBLE);
        write_reg(REG_KEY_ADJ, phase_no[0]);
      end else begin
        write_reg(REG_DIRECTION, 1'($urandom_range(0, 1)));
        write_reg(REG_KEY_ADJ, 1'($urandom_range(0, 1)));
      end
      steady_phase = (phase_no % 3 == 1);
      if (phase_no == 2) begin
        hold_asks++;   // receiver backs off while requests keep coming
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        play_stream(n);
        phase_bytes += n;
      end
      rand_bytes += phase_bytes;
      phase_no++;
    end

    // drain, then give stray results a chance to show up
    in_tvalid <= 1'b0;
    while (awaited_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 3) @(posedge clk);
    if (errors == 0 && awaited_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
